FILE: sv/stk_pkg.sv
package stk_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int K_MAX_DEF   = 32;
  localparam int ROW_MAX_DEF = 65536;

  // Fixed field widths
  localparam int KEY_W  = 32;
  localparam int POS_W  = 16;
  localparam int KCFG_W = 6;

  // Register file
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-1:0] ADDR_K_COUNT = 3'd0;
  localparam logic [KCFG_W-1:0] K_COUNT_RST  = 6'd1;

  // Per-cycle command broadcast along the cell chain
  typedef struct packed {
    logic             insert;  // an element is taken in this cycle
    logic             shift;   // drain: every cell takes its right neighbor
    logic [KEY_W-1:0] key;     // key of the incoming element
    logic [POS_W-1:0] pos;     // row position of the incoming element
  } stk_ctrl_t;

  // Strict signed order of two keys
  function automatic logic key_above(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    key_above = $signed(a) > $signed(b);
  endfunction

endpackage

FILE: sv/stk_cell.sv
module stk_cell (
  input  logic                      clk,
  input  stk_pkg::stk_ctrl_t        ctrl,
  input  logic                      active,      // this slot holds a kept entry
  input  logic                      in_k,        // this slot lies below k
  input  logic                      left_above,  // new key ranks above left slot
  input  logic [stk_pkg::KEY_W-1:0] left_key,
  input  logic [stk_pkg::POS_W-1:0] left_pos,
  input  logic [stk_pkg::KEY_W-1:0] right_key,
  input  logic [stk_pkg::POS_W-1:0] right_pos,
  output logic [stk_pkg::KEY_W-1:0] key,
  output logic [stk_pkg::POS_W-1:0] pos,
  output logic                      above,
  output logic                      take
);

  // Empty slots rank below everything; equal keys never displace
  assign above = !active || stk_pkg::key_above(ctrl.key, key);

  // First slot that the new key beats takes it
  assign take = ctrl.insert && in_k && above && !left_above;

  // Hold, shift down on insert, shift up on drain
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key <= right_key;
      pos <= right_pos;
    end else if (ctrl.insert && in_k && left_above) begin
      key <= left_key;
      pos <= left_pos;
    end else if (take) begin
      key <= ctrl.key;
      pos <= ctrl.pos;
    end
  end

endmodule

FILE: sv/streaming_arg_top_k.sv
// A row's first result is registered once its row_end transfer has moved the sequencer to DRAIN and a drain step runs.
// Throughput: one sample per cycle within a row; a row of n kept entries then
//   drains at one result per cycle unless result_stall holds it, with sample_stall high.
// The sorted insertion chain of K_MAX cells sets the one-sample-per-cycle rate.
// Reset (rst, synchronous): clears entry count, row position, drain state and
//   result_valid; k_count returns to 1. Cell contents are not cleared.
module streaming_arg_top_k #(
  parameter int K_MAX   = stk_pkg::K_MAX_DEF,
  parameter int ROW_MAX = stk_pkg::ROW_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // sample channel
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic [stk_pkg::KEY_W-1:0]  sample_key,
  input  logic                       row_end,
  // result channel
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [stk_pkg::POS_W-1:0]  position,
  output logic [stk_pkg::KEY_W-1:0]  key_out,
  output logic                       final_rank,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [stk_pkg::ADDR_W-1:0] paddr,
  input  logic [stk_pkg::DATA_W-1:0] pwdata,
  output logic [stk_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int KW  = $clog2(K_MAX + 1);
  localparam int RPW = (ROW_MAX > 2) ? $clog2(ROW_MAX) : 1;
  localparam int PXW = (RPW > stk_pkg::POS_W) ? RPW : stk_pkg::POS_W;
  localparam logic [RPW-1:0] ROW_LAST = RPW'(ROW_MAX - 1);

  typedef enum logic {COLLECT, DRAIN} state_t;

  state_t                      state;
  logic [stk_pkg::KCFG_W-1:0]  k_count;
  logic [KW-1:0]               held_count;
  logic [KW-1:0]               remaining;
  logic [RPW-1:0]              row_position;

  logic [KW-1:0]               k_eff;
  logic [KW-1:0]               n_used;
  logic [KW-1:0]               n_after;
  logic [PXW-1:0]              pos_ext;
  logic                        sample_take;
  logic                        drain_go;
  logic                        any_take;
  stk_pkg::stk_ctrl_t          ctrl;

  logic [stk_pkg::KEY_W-1:0]   cell_key   [K_MAX];
  logic [stk_pkg::POS_W-1:0]   cell_pos   [K_MAX];
  logic [K_MAX-1:0]            cell_above;
  logic [K_MAX-1:0]            cell_take;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == stk_pkg::ADDR_K_COUNT) ?
                  stk_pkg::DATA_W'(k_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_count <= stk_pkg::K_COUNT_RST;
    end else if (psel && penable && pwrite && paddr == stk_pkg::ADDR_K_COUNT) begin
      k_count <= pwdata[stk_pkg::KCFG_W-1:0];
    end
  end

  // Clamp k to 1..K_MAX
  always_comb begin
    if (k_count == '0) begin
      k_eff = KW'(1);
    end else if (int'(k_count) > K_MAX) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(k_count);
    end
  end

  assign n_used  = (held_count < k_eff) ? held_count : k_eff;
  assign any_take = |cell_take;
  assign n_after = (any_take && n_used < k_eff) ? n_used + KW'(1) : n_used;

  assign sample_stall = (state == DRAIN);
  assign sample_take  = sample_valid && !sample_stall;
  assign drain_go     = (state == DRAIN) && (!result_valid || !result_stall);

  assign pos_ext = PXW'(row_position);

  assign ctrl.insert = sample_take;
  assign ctrl.shift  = drain_go;
  assign ctrl.key    = sample_key;
  assign ctrl.pos    = pos_ext[stk_pkg::POS_W-1:0];

  // Insertion chain
  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    logic                      left_above;
    logic [stk_pkg::KEY_W-1:0] left_key;
    logic [stk_pkg::POS_W-1:0] left_pos;
    logic [stk_pkg::KEY_W-1:0] right_key;
    logic [stk_pkg::POS_W-1:0] right_pos;

    if (i == 0) begin : g_head
      assign left_above = 1'b0;
      assign left_key   = '0;
      assign left_pos   = '0;
    end else begin : g_mid
      assign left_above = cell_above[i-1];
      assign left_key   = cell_key[i-1];
      assign left_pos   = cell_pos[i-1];
    end

    if (i == K_MAX - 1) begin : g_tail
      assign right_key = '0;
      assign right_pos = '0;
    end else begin : g_body
      assign right_key = cell_key[i+1];
      assign right_pos = cell_pos[i+1];
    end

    stk_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .active     (KW'(i) < n_used),
      .in_k       (KW'(i) < k_eff),
      .left_above (left_above),
      .left_key   (left_key),
      .left_pos   (left_pos),
      .right_key  (right_key),
      .right_pos  (right_pos),
      .key        (cell_key[i]),
      .pos        (cell_pos[i]),
      .above      (cell_above[i]),
      .take       (cell_take[i])
    );
  end

  // Row control, drain sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= COLLECT;
      held_count   <= '0;
      remaining    <= '0;
      row_position <= '0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        COLLECT: begin
          if (sample_take) begin
            if (row_end) begin
              held_count   <= '0;
              row_position <= '0;
              remaining    <= n_after;
              state        <= DRAIN;
            end else begin
              if (any_take) begin
                held_count <= n_after;
              end
              if (row_position != ROW_LAST) begin
                row_position <= row_position + RPW'(1);
              end
            end
          end
        end
        DRAIN: begin
          if (drain_go) begin
            remaining <= remaining - KW'(1);
            if (remaining == KW'(1)) begin
              state <= COLLECT;
            end
          end
        end
        default: state <= COLLECT;
      endcase

      // Load result on a drain step, drop it once transferred
      if (drain_go) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain_go) begin
      position   <= cell_pos[0];
      key_out    <= cell_key[0];
      final_rank <= (remaining == KW'(1));
    end
  end

endmodule

FILE: sv/stk_check.sv
module stk_check (
  input logic clk,
  input logic rst,
  input logic sample_valid,
  input logic sample_stall,
  input logic row_end,
  input logic result_valid,
  input logic result_stall,
  input logic final_rank,
  input logic [31:0] key_out
);

  // A stalled result stays offered
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its key
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(key_out))
    else $error("result key changed while stalled");

  // Row end starts the drain: samples are held back next cycle
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && row_end |=> sample_stall)
    else $error("sample taken right after row end");

  // While a row's results are still pending, no sample is taken
  a_drain_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid && !final_rank |-> sample_stall)
    else $error("sample taken during drain");

endmodule

bind streaming_arg_top_k stk_check u_stk_check (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .row_end      (row_end),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .final_rank   (final_rank),
  .key_out      (key_out)
);
